// ----- rtl/core/svgf_pkg.sv -----
// Shared widths, register map and reset values for the stable value gate filter.
`timescale 1ns / 1ps
package svgf_pkg;

    localparam int VALUE_WIDTH    = 24;
    localparam int TIME_WIDTH     = 32;
    localparam int CFG_TIME_WIDTH = 24;
    localparam int QUARTER_SHIFT  = 2;

    localparam int PROD_WIDTH     = VALUE_WIDTH + TIME_WIDTH;
    localparam int DEN_WIDTH      = TIME_WIDTH + 1;
    localparam int CNT_WIDTH      = $clog2(VALUE_WIDTH + 1);

    localparam int IN_TDATA_WIDTH  = ((VALUE_WIDTH + TIME_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TUSER_WIDTH = 2;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int REG_SEL_WIDTH  = APB_ADDR_WIDTH - 2;

    localparam logic [REG_SEL_WIDTH-1:0] REG_MIN_VALUE    = 3'd0;
    localparam logic [REG_SEL_WIDTH-1:0] REG_MAX_VALUE    = 3'd1;
    localparam logic [REG_SEL_WIDTH-1:0] REG_MAX_JUMP     = 3'd2;
    localparam logic [REG_SEL_WIDTH-1:0] REG_TAU_TIME     = 3'd3;
    localparam logic [REG_SEL_WIDTH-1:0] REG_CONFIRM_TIME = 3'd4;
    localparam logic [REG_SEL_WIDTH-1:0] REG_TIMEOUT_TIME = 3'd5;

    typedef logic [VALUE_WIDTH-1:0]    t_value;
    typedef logic [TIME_WIDTH-1:0]     t_time;
    typedef logic [CFG_TIME_WIDTH-1:0] t_cfg_time;

    localparam t_value    RST_MIN_VALUE    = '0;
    localparam t_value    RST_MAX_VALUE    = '1;
    localparam t_value    RST_MAX_JUMP     = t_value'(256);
    localparam t_cfg_time RST_TAU_TIME     = t_cfg_time'(1000);
    localparam t_cfg_time RST_CONFIRM_TIME = t_cfg_time'(1000);
    localparam t_cfg_time RST_TIMEOUT_TIME = t_cfg_time'(5000);

endpackage

// ----- rtl/core/stable_value_gate_filter.sv -----
// Plausibility-gated candidate tracker with first-order low-pass filter and serial divider.
// Input is latched in idle, then passes the expire, evaluate and output states; a low-pass
// step adds multiply, divide and round states. A new input is taken only back in idle.
// The restoring subtract/compare divider yields one quotient bit per cycle.
// A stalled result output holds the sequencer until the result is taken.
// Reset (synchronous, active low) clears all filter state and loads register defaults.
`timescale 1ns / 1ps
module stable_value_gate_filter
    import svgf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,   // sample_value, now_time
    input  logic [0:0]                 s_axis_tuser,   // sample_present
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,   // filtered_value
    output logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser,   // is_stable, sample_accepted
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [APB_DATA_WIDTH-1:0]  pwdata,
    output logic [APB_DATA_WIDTH-1:0]  prdata,
    output logic                       pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPIRE = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_ROUND  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // configuration
    t_value    r_min_value, r_max_value, r_max_jump;
    t_cfg_time r_tau_time, r_confirm_time, r_timeout_time;

    // sequencer and latched input
    logic [2:0] r_state;
    logic       r_present;
    t_value     r_x;
    t_time      r_now;
    logic       r_acc;

    // filter state
    logic   r_cand_on, r_stable, r_lp_on, r_seen;
    t_value r_cand, r_smooth;
    t_time  r_cand_start, r_last_accept, r_lp_last;

    // divider
    t_value                 r_d;
    t_time                  r_dt;
    logic [DEN_WIDTH-1:0]   r_den;
    logic                   r_up;
    logic [DEN_WIDTH-1:0]   r_rem;
    t_value                 r_shift;
    t_value                 r_q;
    logic [CNT_WIDTH-1:0]   r_cnt;

    // output register
    logic                       r_m_valid;
    t_value                     r_m_data;
    logic [OUT_TUSER_WIDTH-1:0] r_m_user;

    logic                       wr_en;
    logic [REG_SEL_WIDTH-1:0]   reg_sel;
    logic                       in_xfer;
    logic                       out_free;

    logic                       expired;
    logic                       accepted;
    t_value                     dev;
    logic                       restart;
    logic [VALUE_WIDTH:0]       dev_up;
    t_value                     cand_step;
    logic                       confirmed;
    t_time                      dt;
    logic [DEN_WIDTH-1:0]       den;
    logic                       x_ge_s;
    t_value                     sdiff;
    logic [PROD_WIDTH-1:0]      prod;
    logic [DEN_WIDTH:0]         trial;
    logic                       q_bit;
    logic                       round_up;
    t_value                     step;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_sel)
            REG_MIN_VALUE:    prdata = APB_DATA_WIDTH'(r_min_value);
            REG_MAX_VALUE:    prdata = APB_DATA_WIDTH'(r_max_value);
            REG_MAX_JUMP:     prdata = APB_DATA_WIDTH'(r_max_jump);
            REG_TAU_TIME:     prdata = APB_DATA_WIDTH'(r_tau_time);
            REG_CONFIRM_TIME: prdata = APB_DATA_WIDTH'(r_confirm_time);
            REG_TIMEOUT_TIME: prdata = APB_DATA_WIDTH'(r_timeout_time);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value    <= RST_MIN_VALUE;
            r_max_value    <= RST_MAX_VALUE;
            r_max_jump     <= RST_MAX_JUMP;
            r_tau_time     <= RST_TAU_TIME;
            r_confirm_time <= RST_CONFIRM_TIME;
            r_timeout_time <= RST_TIMEOUT_TIME;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MIN_VALUE:    r_min_value    <= pwdata[VALUE_WIDTH-1:0];
                REG_MAX_VALUE:    r_max_value    <= pwdata[VALUE_WIDTH-1:0];
                REG_MAX_JUMP:     r_max_jump     <= pwdata[VALUE_WIDTH-1:0];
                REG_TAU_TIME:     r_tau_time     <= pwdata[CFG_TIME_WIDTH-1:0];
                REG_CONFIRM_TIME: r_confirm_time <= pwdata[CFG_TIME_WIDTH-1:0];
                REG_TIMEOUT_TIME: r_timeout_time <= pwdata[CFG_TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_WIDTH'(r_m_data);
    assign m_axis_tuser  = r_m_user;

    always_comb begin
        expired   = r_seen && ((r_now - r_last_accept) > TIME_WIDTH'(r_timeout_time));
        accepted  = r_present && (r_x >= r_min_value) && (r_x <= r_max_value);
        dev       = (r_x >= r_cand) ? (r_x - r_cand) : (r_cand - r_x);
        restart   = !r_cand_on || (dev > r_max_jump);
        dev_up    = ({1'b0, dev} + (VALUE_WIDTH+1)'(3)) >> QUARTER_SHIFT;
        cand_step = (r_x >= r_cand) ? (r_cand + (dev >> QUARTER_SHIFT))
                                    : (r_cand - dev_up[VALUE_WIDTH-1:0]);
        confirmed = (r_now - r_cand_start) >= TIME_WIDTH'(r_confirm_time);
        dt        = r_now - r_lp_last;
        den       = {1'b0, dt} + DEN_WIDTH'(r_tau_time);
        x_ge_s    = (r_x >= r_smooth);
        sdiff     = x_ge_s ? (r_x - r_smooth) : (r_smooth - r_x);
        prod      = PROD_WIDTH'(r_d) * PROD_WIDTH'(r_dt);
        trial     = {r_rem, r_shift[VALUE_WIDTH-1]};
        q_bit     = (trial >= {1'b0, r_den});
        round_up  = ({r_rem, 1'b0} >= {1'b0, r_den});
        step      = r_q + VALUE_WIDTH'(round_up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cand_on     <= 1'b0;
            r_stable      <= 1'b0;
            r_lp_on       <= 1'b0;
            r_seen        <= 1'b0;
            r_cand        <= '0;
            r_smooth      <= '0;
            r_cand_start  <= '0;
            r_last_accept <= '0;
            r_lp_last     <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_present <= s_axis_tuser[0];
                        r_x       <= s_axis_tdata[VALUE_WIDTH-1:0];
                        r_now     <= s_axis_tdata[VALUE_WIDTH+TIME_WIDTH-1:VALUE_WIDTH];
                        r_state   <= S_EXPIRE;
                    end
                end
                S_EXPIRE: begin
                    if (expired) begin
                        r_cand_on     <= 1'b0;
                        r_stable      <= 1'b0;
                        r_lp_on       <= 1'b0;
                        r_seen        <= 1'b0;
                        r_cand        <= '0;
                        r_smooth      <= '0;
                        r_cand_start  <= '0;
                        r_last_accept <= '0;
                        r_lp_last     <= '0;
                    end
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_acc   <= accepted;
                    r_state <= S_OUT;
                    if (accepted) begin
                        r_last_accept <= r_now;
                        r_seen        <= 1'b1;
                        if (restart) begin
                            r_cand_on    <= 1'b1;
                            r_cand       <= r_x;
                            r_cand_start <= r_now;
                            r_stable     <= 1'b0;
                            r_lp_on      <= 1'b0;
                        end else begin
                            r_cand <= cand_step;
                            if (confirmed) begin
                                r_stable  <= 1'b1;
                                r_lp_last <= r_now;
                                if (!r_lp_on) begin
                                    r_smooth <= r_x;
                                    r_lp_on  <= 1'b1;
                                end else if (den == '0) begin
                                    r_smooth <= r_x;
                                end else begin
                                    r_d     <= sdiff;
                                    r_dt    <= dt;
                                    r_den   <= den;
                                    r_up    <= x_ge_s;
                                    r_state <= S_MUL;
                                end
                            end
                        end
                    end
                end
                S_MUL: begin
                    // product / den < 2^VALUE_WIDTH, so upper bits seed the remainder
                    r_rem   <= DEN_WIDTH'(prod[PROD_WIDTH-1:VALUE_WIDTH]);
                    r_shift <= prod[VALUE_WIDTH-1:0];
                    r_cnt   <= CNT_WIDTH'(VALUE_WIDTH);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= q_bit ? DEN_WIDTH'(trial - {1'b0, r_den})
                                     : trial[DEN_WIDTH-1:0];
                    r_q     <= {r_q[VALUE_WIDTH-2:0], q_bit};
                    r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
                    r_cnt   <= r_cnt - CNT_WIDTH'(1);
                    if (r_cnt == CNT_WIDTH'(1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_smooth <= r_up ? (r_smooth + step) : (r_smooth - step);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_user  <= {r_acc, r_stable && r_lp_on};
                        r_m_data  <= (r_stable && r_lp_on) ? r_smooth : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/svgf_checker.sv -----
// Port-level checks for the stable value gate filter, bound to the top level.
`timescale 1ns / 1ps
module svgf_checker
    import svgf_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    input logic [0:0]                 s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [APB_ADDR_WIDTH-1:0]  paddr,
    input logic [APB_DATA_WIDTH-1:0]  pwdata,
    input logic [APB_DATA_WIDTH-1:0]  prdata,
    input logic                       pready
);

    // stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // filtered value reads zero unless stable
    a_zero_unstable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("filtered value nonzero while not stable");

    // one item at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a new result is issued as the sequencer returns to idle
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared with sequencer busy");

    a_prdata_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && prdata[APB_DATA_WIDTH-1:VALUE_WIDTH] == '0)
        else $error("register readback out of range");

endmodule

bind stable_value_gate_filter svgf_checker u_svgf_checker (.*);

// ----- verif/tb_stable_value_gate_filter.sv -----
// Self-checking testbench for the stable value gate filter: stream in/out, APB setup.
`timescale 1ns / 1ps
module tb_stable_value_gate_filter;
    import svgf_pkg::*;

    typedef struct packed {
        logic   is_stable;
        t_value filtered;
        logic   accepted;
    } filter_out_t;

    typedef struct packed {
        logic   present;
        t_value value;
        t_time  now;
        logic   typed;
        logic   st;
        t_value filt;
        logic   acc;
    } dir_row_t;

    typedef struct {
        t_value    lo;
        t_value    hi;
        t_value    jump;
        t_cfg_time tau;
        t_cfg_time confirm;
        t_cfg_time timeout;
        int        dt_max;
        int        tx_pct;
        int        rx_pct;
        int        n_items;
        bit        hold;
    } phase_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;   // sample_value, now_time
    logic [0:0]                 s_axis_tuser = '0;   // sample_present
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;        // filtered_value
    logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser;        // is_stable, sample_accepted
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0]  paddr = '0;
    logic [APB_DATA_WIDTH-1:0]  pwdata = '0;
    logic [APB_DATA_WIDTH-1:0]  prdata;
    logic                       pready;

    stable_value_gate_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // register shadow
    t_value    cfg_min;
    t_value    cfg_max;
    t_value    cfg_jump;
    t_cfg_time cfg_tau;
    t_cfg_time cfg_confirm;
    t_cfg_time cfg_timeout;

    // filter state
    logic   trk_on;
    logic   confirmed;
    logic   lp_on;
    logic   ever_accepted;
    t_value trk_value;
    t_value lp_value;
    t_time  trk_start;
    t_time  last_accept;
    t_time  lp_last;

    filter_out_t awaited_out[$];
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    t_time       gen_time;
    t_value      gen_base;

    dir_row_t dir_rows [19] = '{
        '{1'b0, 24'h000000, 32'h0000_0000, 1'b1, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'h000000, 32'h0000_0000, 1'b1, 1'b0, 24'd0,    1'b1},
        '{1'b1, 24'hFFFFFF, 32'd10,        1'b1, 1'b0, 24'd0,    1'b1},
        '{1'b1, 24'd4096,   32'd20,        1'b1, 1'b0, 24'd0,    1'b1},
        '{1'b1, 24'd4296,   32'd500,       1'b1, 1'b0, 24'd0,    1'b1},
        '{1'b1, 24'd4000,   32'd1020,      1'b1, 1'b1, 24'd4000, 1'b1},
        '{1'b1, 24'd4200,   32'd2020,      1'b1, 1'b1, 24'd4100, 1'b1},
        '{1'b0, 24'hFFFFFF, 32'd3000,      1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5000,   32'd3100,      1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b0, 24'd0,      32'd8101,      1'b1, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5000,   32'd8102,      1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5010,   32'd13102,     1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5020,   32'hFFFF_FFF0, 1'b1, 1'b0, 24'd0,    1'b1},
        '{1'b1, 24'd5020,   32'h0000_0100, 1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5020,   32'h0000_0400, 1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd5100,   32'h0000_0400, 1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'd4900,   32'h0000_0800, 1'b0, 1'b0, 24'd0,    1'b0},
        '{1'b0, 24'hAAAAAA, 32'h5555_5555, 1'b1, 1'b0, 24'd0,    1'b0},
        '{1'b1, 24'h555555, 32'hAAAA_AAAA, 1'b1, 1'b0, 24'd0,    1'b1}
    };

    phase_t phases [7] = '{
        '{24'h000000, 24'hFFFFFF, 24'd256,    24'd1000,   24'd1000,   24'd5000,
          400, 0, 0, 100, 1'b0},
        '{24'h001000, 24'h020000, 24'd0,      24'd0,      24'd0,      24'd3000,
          300, 75, 0, 80, 1'b0},
        '{24'h000800, 24'hF00000, 24'hFFFFFF, 24'hFFFFFF, 24'd500,    24'hFFFFFF,
          200, 0, 75, 100, 1'b1},
        '{24'hFFFFFF, 24'h000000, 24'd100,    24'd50,     24'd200,    24'd1000,
          150, 29, 29, 40, 1'b0},
        '{24'hFFFFFF, 24'hFFFFFF, 24'd256,    24'd1,      24'd20,     24'd400,
          30, 0, 0, 40, 1'b0},
        '{24'h000000, 24'hFFFFFF, 24'h004000, 24'd10,     24'hFFFFFF, 24'd0,
          3, 29, 29, 60, 1'b0},
        '{24'h000100, 24'h800000, 24'd2000,   24'd300,    24'd100,    24'd2000,
          120, 0, 0, 200, 1'b1}
    };

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void clear_filter_state();
        trk_on        = 1'b0;
        confirmed     = 1'b0;
        lp_on         = 1'b0;
        ever_accepted = 1'b0;
        trk_value     = '0;
        lp_value      = '0;
        trk_start     = '0;
        last_accept   = '0;
        lp_last       = '0;
    endfunction

    // |d| * dt / den, rounded to nearest with ties away from zero
    function automatic t_value lowpass_delta(input t_value mag, input t_time dt,
                                             input logic [TIME_WIDTH:0] den);
        logic [PROD_WIDTH-1:0] prod;
        logic [PROD_WIDTH-1:0] quo;
        logic [PROD_WIDTH-1:0] rem;
        prod = PROD_WIDTH'(mag) * PROD_WIDTH'(dt);
        quo  = prod / PROD_WIDTH'(den);
        rem  = prod % PROD_WIDTH'(den);
        if (rem >= PROD_WIDTH'(den) - rem)
            quo = quo + 1'b1;
        return quo[VALUE_WIDTH-1:0];
    endfunction

    function automatic filter_out_t gate_and_smooth(input logic present, input t_value x,
                                                     input t_time now);
        filter_out_t          res;
        t_value               dev;
        t_time                dt;
        logic [TIME_WIDTH:0]  den;
        logic                 accepted;
        if (ever_accepted && t_time'(now - last_accept) > t_time'(cfg_timeout))
            clear_filter_state();
        accepted = present && x >= cfg_min && x <= cfg_max;
        if (accepted) begin
            dev = (x >= trk_value) ? x - trk_value : trk_value - x;
            last_accept   = now;
            ever_accepted = 1'b1;
            if (!trk_on || dev > cfg_jump) begin
                trk_on    = 1'b1;
                trk_value = x;
                trk_start = now;
                confirmed = 1'b0;
                lp_on     = 1'b0;
            end else begin
                if (x >= trk_value)
                    trk_value = trk_value + (dev >> QUARTER_SHIFT);
                else
                    trk_value = trk_value
                              - t_value'(((VALUE_WIDTH+1)'(dev) + 3) >> QUARTER_SHIFT);
                if (t_time'(now - trk_start) >= t_time'(cfg_confirm)) begin
                    confirmed = 1'b1;
                    if (!lp_on) begin
                        lp_value = x;
                        lp_on    = 1'b1;
                        lp_last  = now;
                    end else begin
                        dt      = now - lp_last;
                        den     = {1'b0, dt} + (TIME_WIDTH+1)'(cfg_tau);
                        lp_last = now;
                        if (den == '0)
                            lp_value = x;
                        else if (x >= lp_value)
                            lp_value = lp_value + lowpass_delta(x - lp_value, dt, den);
                        else
                            lp_value = lp_value - lowpass_delta(lp_value - x, dt, den);
                    end
                end
            end
        end
        res.is_stable = confirmed && lp_on;
        res.filtered  = res.is_stable ? lp_value : '0;
        res.accepted  = accepted;
        return res;
    endfunction

    // called on a rising edge; returns on the edge that completes the transfer
    task automatic send_reading(input logic present, input t_value x, input t_time now,
                                input logic typed, input filter_out_t typed_out);
        filter_out_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, x};
        s_axis_tuser  <= present;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = gate_and_smooth(present, x, now);
        awaited_out.push_back(typed ? typed_out : predicted);
    endtask

    task automatic apb_access(input logic wr, input logic [REG_SEL_WIDTH-1:0] sel,
                              input logic [APB_DATA_WIDTH-1:0] data,
                              output logic [APB_DATA_WIDTH-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_and_check_reg(input logic [REG_SEL_WIDTH-1:0] sel, input t_value v);
        logic [APB_DATA_WIDTH-1:0] rd;
        logic [APB_DATA_WIDTH-1:0] junk;
        junk = APB_DATA_WIDTH'($urandom);
        apb_access(1'b1, sel, {junk[31:24], v}, rd);
        case (sel)
            REG_MIN_VALUE:    cfg_min     = v;
            REG_MAX_VALUE:    cfg_max     = v;
            REG_MAX_JUMP:     cfg_jump    = v;
            REG_TAU_TIME:     cfg_tau     = v;
            REG_CONFIRM_TIME: cfg_confirm = v;
            REG_TIMEOUT_TIME: cfg_timeout = v;
            default: ;
        endcase
        apb_access(1'b0, sel, '0, rd);
        if (rd !== APB_DATA_WIDTH'(v))
            flag_mismatch($sformatf("reg %0d reads %h, wrote %h", sel, rd, v));
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (awaited_out.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_value pick_in_range();
        if (cfg_min <= cfg_max)
            return t_value'($urandom_range(cfg_max, cfg_min));
        return t_value'($urandom_range(24'hFFFFFF));
    endfunction

    task automatic make_reading(input int dt_max, output logic present, output t_value x,
                                output t_time now);
        int unsigned r;
        int unsigned mag;
        int unsigned lim;
        longint      v;
        r = $urandom_range(99);
        if (r < 4)
            gen_time = t_time'($urandom);
        else if (r < 8)
            gen_time = gen_time + t_time'(cfg_timeout) + t_time'($urandom_range(2));
        else if (r >= 15)
            gen_time = gen_time + t_time'($urandom_range(dt_max, 1));
        now = gen_time;

        if ($urandom_range(99) < 3)
            gen_base = pick_in_range();
        present = 1'b1;
        r = $urandom_range(99);
        if (r < 6) begin
            present = 1'b0;
            x = t_value'($urandom);
        end else if (r < 10) begin
            x = t_value'($urandom);
        end else if (r < 14) begin
            if (cfg_min > 0)
                x = t_value'($urandom_range(cfg_min - 1));
            else if (cfg_max < 24'hFFFFFF)
                x = t_value'($urandom_range(24'hFFFFFF, cfg_max + 1));
            else
                x = t_value'($urandom);
        end else begin
            lim = (cfg_jump > 24'd4000) ? 4000 : cfg_jump;
            mag = ($urandom_range(99) < 8) ? cfg_jump + 1 : $urandom_range(lim / 2);
            v = $urandom_range(1) ? longint'(gen_base) + mag : longint'(gen_base) - mag;
            if (v < 0)
                v = 0;
            if (v > 24'hFFFFFF)
                v = 24'hFFFFFF;
            x = t_value'(v);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        filter_out_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_out.size() == 0) begin
                flag_mismatch("result transfer with nothing outstanding");
            end else begin
                want = awaited_out.pop_front();
                if (m_axis_tuser[0] !== want.is_stable)
                    flag_mismatch($sformatf("is_stable %b, want %b",
                                            m_axis_tuser[0], want.is_stable));
                if (m_axis_tuser[1] !== want.accepted)
                    flag_mismatch($sformatf("sample_accepted %b, want %b",
                                            m_axis_tuser[1], want.accepted));
                if (m_axis_tdata[VALUE_WIDTH-1:0] !== want.filtered)
                    flag_mismatch($sformatf("filtered_value %h, want %h",
                                            m_axis_tdata[VALUE_WIDTH-1:0], want.filtered));
            end
        end
    end

    initial begin
        filter_out_t typed_out;
        logic        present;
        t_value      x;
        t_time       now;

        cfg_min     = RST_MIN_VALUE;
        cfg_max     = RST_MAX_VALUE;
        cfg_jump    = RST_MAX_JUMP;
        cfg_tau     = RST_TAU_TIME;
        cfg_confirm = RST_CONFIRM_TIME;
        cfg_timeout = RST_TIMEOUT_TIME;
        clear_filter_state();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            typed_out = '{dir_rows[i].st, dir_rows[i].filt, dir_rows[i].acc};
            send_reading(dir_rows[i].present, dir_rows[i].value, dir_rows[i].now,
                         dir_rows[i].typed, typed_out);
        end

        gen_time = t_time'($urandom);
        foreach (phases[p]) begin
            drain_outputs();
            tx_idle_pct  = phases[p].tx_pct;
            rx_stall_pct = phases[p].rx_pct;
            write_and_check_reg(REG_MIN_VALUE,    phases[p].lo);
            write_and_check_reg(REG_MAX_VALUE,    phases[p].hi);
            write_and_check_reg(REG_MAX_JUMP,     phases[p].jump);
            write_and_check_reg(REG_TAU_TIME,     phases[p].tau);
            write_and_check_reg(REG_CONFIRM_TIME, phases[p].confirm);
            write_and_check_reg(REG_TIMEOUT_TIME, phases[p].timeout);
            gen_base = pick_in_range();
            if (phases[p].hold)
                hold_req = 1'b1;
            repeat (phases[p].n_items) begin
                make_reading(phases[p].dt_max, present, x, now);
                send_reading(present, x, now, 1'b0, '0);
            end
        end

        drain_outputs();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
